// File: rtl/erdd_pkg.sv
// Shared types and constants for the escape run-length dictionary decompressor.
package erdd_pkg;

    localparam int unsigned DICT_ENTRIES = 16;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned DICT_W       = 64;
    localparam int unsigned CNT_W        = 4;
    localparam int unsigned CFG_IDX_W    = 2;

    localparam logic [BYTE_W-1:0] ESCAPE_BYTE  = 8'h07;
    localparam logic [BYTE_W-1:0] LITERAL_CODE = 8'h00;
    localparam logic [CNT_W-1:0]  NIBBLE_MASK  = 4'hF;

    localparam logic [CFG_IDX_W-1:0] CFG_DICT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DICT_HIGH = 2'd1;

    typedef enum logic [1:0]
    {
        S_ACCEPT = 2'b01,
        S_RUN    = 2'b10
    } state_t;

    typedef struct packed
    {
        logic in_take;
        logic esc_pending;
        logic run_step;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic slot_free;
        logic more;
        logic rem_last;
        logic is_esc;
    } dp_status_t;

endpackage

// File: rtl/erdd_ctrl.sv
// Controller state machine: input acceptance, escape tracking and run sequencing.
module erdd_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   is_final,
    input  erdd_pkg::dp_status_t   status,
    output erdd_pkg::ctrl_cmd_t    cmd
);

    erdd_pkg::state_t state_reg;
    erdd_pkg::state_t state_next;
    logic             esc_reg;
    logic             esc_next;
    logic             take;

    assign in_ready = (state_reg == erdd_pkg::S_ACCEPT) && status.slot_free;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        esc_next   = esc_reg;
        case (state_reg)
            erdd_pkg::S_ACCEPT:
            begin
                if (take)
                begin
                    if (is_final || esc_reg)
                    begin
                        esc_next = 1'b0;
                    end
                    else if (status.is_esc)
                    begin
                        esc_next = 1'b1;
                    end
                    if (status.more)
                    begin
                        state_next = erdd_pkg::S_RUN;
                    end
                end
            end
            erdd_pkg::S_RUN:
            begin
                if (status.slot_free && status.rem_last)
                begin
                    state_next = erdd_pkg::S_ACCEPT;
                end
            end
            default:
            begin
                state_next = erdd_pkg::S_ACCEPT;
            end
        endcase
    end

    always_comb
    begin
        cmd.in_take     = take;
        cmd.esc_pending = esc_reg;
        cmd.run_step    = (state_reg == erdd_pkg::S_RUN) && status.slot_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= erdd_pkg::S_ACCEPT;
            esc_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            esc_reg   <= esc_next;
        end
    end

    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == erdd_pkg::S_RUN) |-> !in_ready)
        else $error("input accepted during run");

    a_esc_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        (take && esc_reg) |=> !esc_reg)
        else $error("escape pending survived its code byte");

endmodule

// File: rtl/erdd_datapath.sv
// Datapath: dictionary registers, byte decode, run counter and output register.
module erdd_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [erdd_pkg::BYTE_W-1:0]  in_byte,
    input  logic                         is_final,
    input  logic                         cfg_valid,
    input  logic [erdd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [erdd_pkg::DICT_W-1:0]  cfg_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [erdd_pkg::BYTE_W-1:0]  out_byte,
    output logic                         run_end,
    output logic                         stream_end,
    input  erdd_pkg::ctrl_cmd_t          cmd,
    output erdd_pkg::dp_status_t         status
);

    logic [erdd_pkg::DICT_W-1:0] dict_low_reg;
    logic [erdd_pkg::DICT_W-1:0] dict_high_reg;
    logic                        out_valid_reg;
    logic [erdd_pkg::BYTE_W-1:0] out_byte_reg;
    logic                        run_end_reg;
    logic                        stream_end_reg;
    logic [erdd_pkg::BYTE_W-1:0] run_byte_reg;
    logic                        run_fin_reg;
    logic [erdd_pkg::CNT_W-1:0]  rem_reg;

    logic [erdd_pkg::CNT_W-1:0]  code_cnt;
    logic [erdd_pkg::CNT_W-1:0]  code_idx;
    logic [erdd_pkg::DICT_W-1:0] dict_half;
    logic [erdd_pkg::BYTE_W-1:0] dict_val;
    logic [erdd_pkg::BYTE_W-1:0] dec_val;
    logic                        dec_emit;
    logic                        dec_more;
    logic                        load_first;

    assign code_cnt  = in_byte[7:4] & erdd_pkg::NIBBLE_MASK;
    assign code_idx  = in_byte[3:0] & erdd_pkg::NIBBLE_MASK;
    assign dict_half = code_idx[3] ? dict_high_reg : dict_low_reg;
    assign dict_val  = dict_half[{code_idx[2:0], 3'b000} +: erdd_pkg::BYTE_W];

    always_comb
    begin
        dec_val  = in_byte;
        dec_emit = 1'b1;
        dec_more = 1'b0;
        if (cmd.esc_pending)
        begin
            if (in_byte == erdd_pkg::LITERAL_CODE)
            begin
                dec_val = erdd_pkg::ESCAPE_BYTE;
            end
            else
            begin
                dec_val  = dict_val;
                dec_emit = (code_cnt != '0);
                dec_more = (code_cnt > 4'd1);
            end
        end
        else if (in_byte == erdd_pkg::ESCAPE_BYTE)
        begin
            dec_emit = is_final;
        end
    end

    assign load_first = cmd.in_take && dec_emit;

    always_comb
    begin
        status.slot_free = !out_valid_reg || out_ready;
        status.more      = dec_more;
        status.rem_last  = (rem_reg == 4'd1);
        status.is_esc    = (in_byte == erdd_pkg::ESCAPE_BYTE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dict_low_reg  <= '0;
            dict_high_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == erdd_pkg::CFG_DICT_LOW)
            begin
                dict_low_reg <= cfg_data;
            end
            else if (cfg_index == erdd_pkg::CFG_DICT_HIGH)
            begin
                dict_high_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end
        else
        begin
            if (load_first || cmd.run_step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (load_first)
            begin
                rem_reg <= dec_more ? code_cnt - 4'd1 : '0;
            end
            else if (cmd.run_step)
            begin
                rem_reg <= rem_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_first)
        begin
            out_byte_reg   <= dec_val;
            run_end_reg    <= !dec_more;
            stream_end_reg <= is_final;
            run_byte_reg   <= dec_val;
            run_fin_reg    <= is_final;
        end
        else if (cmd.run_step)
        begin
            out_byte_reg   <= run_byte_reg;
            run_end_reg    <= (rem_reg == 4'd1);
            stream_end_reg <= run_fin_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign run_end    = run_end_reg;
    assign stream_end = stream_end_reg;

    a_step_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run_step |-> (rem_reg != '0))
        else $error("run step with empty counter");

    a_step_excl_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run_step |-> !cmd.in_take)
        else $error("run step and input beat together");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (load_first || cmd.run_step) |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

// File: rtl/escape_rle_dictionary_decompress_top.sv
// Top level of the escape run-length dictionary decompressor.
//
//  channel | signals                                   | beat
//  --------+-------------------------------------------+------------------------
//  in      | in_valid in_ready in_byte is_final        | one compressed byte
//  out     | out_valid out_ready out_byte run_end      | one decompressed byte
//          | stream_end                                |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | one dictionary word
//
//  Literal bytes: one beat per cycle while out is not stalled, the output register parting the two sides.
//  A run of N copies holds the input until its last copy is loaded, paced by the run counter.
//  Escape bytes not marked final and zero-length runs give no result.
//  Reset clears the dictionary, escape flag, run counter and output valid.
//  A stall on out holds the output register and blocks in.
module escape_rle_dictionary_decompress_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [erdd_pkg::BYTE_W-1:0]    in_byte,
    input  logic                           is_final,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [erdd_pkg::BYTE_W-1:0]    out_byte,
    output logic                           run_end,
    output logic                           stream_end,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [erdd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [erdd_pkg::DICT_W-1:0]    cfg_data
);

    erdd_pkg::ctrl_cmd_t  cmd;
    erdd_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    erdd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .is_final (is_final),
        .status   (status),
        .cmd      (cmd)
    );

    erdd_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (in_byte),
        .is_final   (is_final),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_end    (run_end),
        .stream_end (stream_end),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the escape run-length dictionary decompressor.
module tb_top;

    localparam logic [erdd_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [erdd_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int IDLE_PCT      = 29;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 4000;

    typedef struct packed
    {
        logic [erdd_pkg::BYTE_W-1:0] data;
        logic                        last_of_run;
        logic                        last_of_stream;
    } dec_beat_t;

    class decode_ledger;
        logic [erdd_pkg::DICT_W-1:0] dict_lo;
        logic [erdd_pkg::DICT_W-1:0] dict_hi;
        logic                        esc_armed;
        dec_beat_t                   awaited[$];
        int                          errors;

        function new();
            dict_lo   = '0;
            dict_hi   = '0;
            esc_armed = 1'b0;
            errors    = 0;
        endfunction

        function void set_reg(logic [erdd_pkg::CFG_IDX_W-1:0] idx,
                              logic [erdd_pkg::DICT_W-1:0] val);
            if (idx == erdd_pkg::CFG_DICT_LOW)
                dict_lo = val;
            else if (idx == erdd_pkg::CFG_DICT_HIGH)
                dict_hi = val;
        endfunction

        function void queue_beat(logic [erdd_pkg::BYTE_W-1:0] data, logic last, logic fin);
            dec_beat_t e;
            e.data           = data;
            e.last_of_run    = last;
            e.last_of_stream = fin;
            awaited.push_back(e);
        endfunction

        // expected output bytes for one accepted compressed byte
        function void expand_byte(logic [erdd_pkg::BYTE_W-1:0] b, logic fin);
            logic [erdd_pkg::CNT_W-1:0]  count;
            logic [erdd_pkg::BYTE_W-1:0] fill;
            int                          j;
            if (esc_armed)
            begin
                esc_armed = 1'b0;
                if (b == erdd_pkg::LITERAL_CODE)
                    queue_beat(erdd_pkg::ESCAPE_BYTE, 1'b1, fin);
                else
                begin
                    count = b[7:4];
                    fill  = 8'((b[3] ? dict_hi : dict_lo) >> (8 * b[2:0]));
                    for (j = 0; j < count; j++)
                        queue_beat(fill, j == count - 1, fin);
                end
            end
            else if (b == erdd_pkg::ESCAPE_BYTE)
            begin
                if (fin)
                    queue_beat(erdd_pkg::ESCAPE_BYTE, 1'b1, 1'b1);
                else
                    esc_armed = 1'b1;
            end
            else
                queue_beat(b, 1'b1, fin);
            if (fin)
                esc_armed = 1'b0;
        endfunction

        task flag_mismatch(string what, int got, int want);
            errors++;
            $display("mismatch %s: got %0h want %0h", what, got, want);
        endtask

        task match_beat(logic [erdd_pkg::BYTE_W-1:0] data, logic last, logic fin);
            dec_beat_t e;
            if (awaited.size() == 0)
                flag_mismatch("beat with none awaited", data, 0);
            else
            begin
                e = awaited.pop_front();
                if (data != e.data)
                    flag_mismatch("out_byte", data, e.data);
                if (last != e.last_of_run)
                    flag_mismatch("run_end", last, e.last_of_run);
                if (fin != e.last_of_stream)
                    flag_mismatch("stream_end", fin, e.last_of_stream);
            end
        endtask
    endclass

    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           in_valid   = 1'b0;
    logic                           in_ready;
    logic [erdd_pkg::BYTE_W-1:0]    in_byte    = '0;
    logic                           is_final   = 1'b0;
    logic                           out_valid;
    logic                           out_ready  = 1'b0;
    logic [erdd_pkg::BYTE_W-1:0]    out_byte;
    logic                           run_end;
    logic                           stream_end;
    logic                           cfg_valid  = 1'b0;
    logic                           cfg_ready;
    logic [erdd_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
    logic [erdd_pkg::DICT_W-1:0]    cfg_data   = '0;
    logic                           steady     = 1'b0;
    decode_ledger                   ledger;

    escape_rle_dictionary_decompress_top dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .is_final   (is_final),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_end    (run_end),
        .stream_end (stream_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            ledger.expand_byte(in_byte, is_final);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            ledger.match_beat(out_byte, run_end, stream_end);
    end

    always @(negedge clk)
    begin
        out_ready = steady || ($urandom_range(99) >= IDLE_PCT);
    end

    initial
    begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall = 0;
            else
                stall++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_byte(input logic [erdd_pkg::BYTE_W-1:0] b, input logic fin);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_byte  = b;
        is_final = fin;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic load_reg(input logic [erdd_pkg::CFG_IDX_W-1:0] idx,
                            input logic [erdd_pkg::DICT_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        ledger.set_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // hold off input until every expected beat is out, then let the block go quiet
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (ledger.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_burst(input int n_items);
        int                          sent;
        int                          pick;
        logic [erdd_pkg::BYTE_W-1:0] b;
        logic                        fin;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            fin  = ($urandom_range(15) == 0);
            b    = 8'($urandom_range(255));
            if (pick < 45)
            begin
                if (b == erdd_pkg::ESCAPE_BYTE)
                    b = ~b;
                send_byte(b, fin);
                sent += 1;
            end
            else if (pick < 75)
            begin
                send_byte(erdd_pkg::ESCAPE_BYTE, 1'b0);
                send_byte(b, fin);
                sent += 2;
            end
            else if (pick < 85)
            begin
                send_byte(erdd_pkg::ESCAPE_BYTE, 1'b0);
                send_byte(erdd_pkg::LITERAL_CODE, fin);
                sent += 2;
            end
            else if (pick < 90)
            begin
                send_byte(erdd_pkg::ESCAPE_BYTE, 1'b1);
                sent += 1;
            end
            else
            begin
                send_byte(b, 1'($urandom_range(1)));
                sent += 1;
            end
        end
    endtask

    initial
    begin
        ledger = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        load_reg(erdd_pkg::CFG_DICT_LOW, 64'h8877665544332211);
        load_reg(erdd_pkg::CFG_DICT_HIGH, 64'h10FFEEDDCCBBAA99);
        load_reg(CFG_SPARE_2, '1);

        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(erdd_pkg::ESCAPE_BYTE, 1'b0);
        send_byte(erdd_pkg::LITERAL_CODE, 1'b0);
        send_byte(erdd_pkg::ESCAPE_BYTE, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(erdd_pkg::ESCAPE_BYTE, 1'b0);
        send_byte(8'hFF, 1'b0);
        // escape as a code: zero-length run of entry 7
        send_byte(erdd_pkg::ESCAPE_BYTE, 1'b0);
        send_byte(erdd_pkg::ESCAPE_BYTE, 1'b0);
        send_byte(erdd_pkg::ESCAPE_BYTE, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(erdd_pkg::ESCAPE_BYTE, 1'b0);
        send_byte(8'h1E, 1'b0);
        // lone escape closing a stream comes out as a literal
        send_byte(erdd_pkg::ESCAPE_BYTE, 1'b1);
        // zero-length run closing a stream: no beat at all
        send_byte(erdd_pkg::ESCAPE_BYTE, 1'b0);
        send_byte(8'h03, 1'b1);
        send_byte(8'h42, 1'b1);
        send_byte(erdd_pkg::ESCAPE_BYTE, 1'b0);
        send_byte(erdd_pkg::LITERAL_CODE, 1'b1);
        send_byte(erdd_pkg::ESCAPE_BYTE, 1'b0);
        send_byte(8'h3C, 1'b1);
        settle();

        load_reg(erdd_pkg::CFG_DICT_LOW, '0);
        load_reg(erdd_pkg::CFG_DICT_HIGH, '1);
        load_reg(CFG_SPARE_3, {$urandom, $urandom});
        random_burst(40);
        settle();
        random_burst(40);
        settle();

        load_reg(erdd_pkg::CFG_DICT_LOW, '1);
        load_reg(erdd_pkg::CFG_DICT_HIGH, '0);
        steady = 1'b1;
        random_burst(56);
        settle();
        steady = 1'b0;

        load_reg(erdd_pkg::CFG_DICT_LOW, {$urandom, $urandom});
        load_reg(erdd_pkg::CFG_DICT_HIGH, {$urandom, $urandom});
        random_burst(75);
        settle();

        load_reg(erdd_pkg::CFG_DICT_HIGH, {$urandom, $urandom});
        load_reg(erdd_pkg::CFG_DICT_LOW, {$urandom, $urandom});
        random_burst(75);
        settle();

        if (ledger.errors == 0 && ledger.awaited.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
